// ===== design/mpts_pkg.sv =====
`default_nettype none
package mpts_pkg;
    localparam int MaxTasks = 16;

    localparam logic [2:0] PolFcfs = 3'd0;
    localparam logic [2:0] PolRr   = 3'd1;
    localparam logic [2:0] PolSjf  = 3'd2;
    localparam logic [2:0] PolSrtf = 3'd3;
    localparam logic [2:0] PolRm   = 3'd4;
    localparam logic [2:0] PolEdf  = 3'd5;

    localparam logic [2:0] StRan   = 3'd0;
    localparam logic [2:0] StIdle  = 3'd1;
    localparam logic [2:0] StLoad  = 3'd2;
    localparam logic [2:0] StFull  = 3'd3;
    localparam logic [2:0] StLimit = 3'd4;

    localparam logic [1:0] CfgPolicy  = 2'd0;
    localparam logic [1:0] CfgQuantum = 2'd1;
    localparam logic [1:0] CfgLimit   = 2'd2;

    localparam logic CmdLoad = 1'b0;
    localparam logic CmdStep = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ACT_RD, S_ACT_CHK, S_SEL_RD, S_SEL_CHK,
        S_RUN_RD, S_RUN, S_SHIFT_RD, S_SHIFT_WR, S_FIN, S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== design/mpts_in_if.sv =====
`default_nettype none
interface mpts_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] task_id;
    logic [31:0] task_release;
    logic [15:0] task_period;
    logic [15:0] task_length;
    modport source (output valid, cmd, task_id, task_release, task_period, task_length,
                    input ready);
    modport sink (input valid, cmd, task_id, task_release, task_period, task_length,
                  output ready);
endinterface
`default_nettype wire

// ===== design/mpts_out_if.sv =====
`default_nettype none
interface mpts_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] run_task_id;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic        deadline_missed;
    logic        task_finished;
    modport source (output valid, status, run_task_id, start_time, end_time,
                    deadline_missed, task_finished, input ready);
    modport sink (input valid, status, run_task_id, start_time, end_time,
                  deadline_missed, task_finished, output ready);
endinterface
`default_nettype wire

// ===== design/multi_policy_task_scheduler_core.sv =====
`default_nettype none
// Single-core task scheduler with six selection policies.
// in_ch carries items: cmd 0 loads a task into a free slot and appends it to
// the pending list; cmd 1 runs one scheduling step. out_ch returns exactly
// one result item per input item (loaded, table full, ran, idle tick, limit).
// Config: i_cfg_we/i_cfg_idx/i_cfg_data; 0 policy, 1 quantum, 2 time limit.
// Write only while the block is idle.
// Timing: one item at a time. A load or a refused step has its result in the
// output register in the cycle after it is taken. A step walks the pending
// list (read entry, read slot, check per entry), then the ready list for the
// minimum search (read entry, read slot, compare per entry, a single entry
// for fcfs and round robin), runs the pick and, when the task leaves the
// ready list, closes the gap with one shift per entry behind it (read, then
// write). The cost comes from the list memories and slot memory, each with a
// single read port, one read per cycle.
// The result sits in an output register; in_ch.ready stays low until it has
// been taken, so a stalled receiver simply holds the block.
// Reset clears counts, slot usage, time, state and valid, not the result data;
// slot and list memories are undefined until written and need no clearing pass.
module multi_policy_task_scheduler_core #(
    parameter int MAX_TASKS = mpts_pkg::MaxTasks
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    mpts_in_if.sink          in_ch,
    mpts_out_if.source       out_ch
);
    import mpts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] CMAX = CW'(MAX_TASKS);

    // slot memory: id, release, period, length, left
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] rel;
        logic [15:0] per;
        logic [15:0] len;
        logic [15:0] left;
    } t_slot;

    t_slot          slot_mem [MAX_TASKS];
    logic [IW-1:0]  pend_mem [MAX_TASKS];
    logic [IW-1:0]  rdy_mem  [MAX_TASKS];

    logic [2:0]  r_policy;
    logic [15:0] r_quantum;
    logic [31:0] r_limit;

    t_state r_state, n_state;
    logic [CW-1:0] r_pcnt, n_pcnt, r_rcnt, n_rcnt;
    logic [CW-1:0] r_i, n_i, r_kept, n_kept, r_best, n_best;
    logic [MAX_TASKS-1:0] r_use, n_use;
    logic [31:0] r_now, n_now;
    logic [IW-1:0] r_s, n_s, r_bslot, n_bslot;
    logic [32:0] r_bkey, n_bkey;
    logic [2:0]  r_pol, n_pol;

    logic        r_ov, n_ov;
    logic [2:0]  r_ost, n_ost;
    logic [15:0] r_oid, n_oid;
    logic [31:0] r_ost_t, n_ost_t, r_oen, n_oen;
    logic        r_omiss, n_omiss, r_ofin, n_ofin;

    // memory ports
    logic          s_we;  logic [IW-1:0] s_wa, s_ra; t_slot s_wd, r_srd;
    logic          p_we;  logic [IW-1:0] p_wa, p_ra; logic [IW-1:0] p_wd, r_prd;
    logic          q_we;  logic [IW-1:0] q_wa, q_ra; logic [IW-1:0] q_wd, r_qrd;

    always_ff @(posedge i_clk) begin
        if (s_we) slot_mem[s_wa] <= s_wd;
        r_srd <= slot_mem[s_ra];
        if (p_we) pend_mem[p_wa] <= p_wd;
        r_prd <= pend_mem[p_ra];
        if (q_we) rdy_mem[q_wa] <= q_wd;
        r_qrd <= rdy_mem[q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= PolFcfs;
            r_quantum <= 16'd1;
            r_limit   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgPolicy:  r_policy  <= i_cfg_data[2:0];
                CfgQuantum: r_quantum <= i_cfg_data[15:0];
                CfgLimit:   r_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [IW-1:0] free_idx;
    logic          free_ok;
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int k = MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_use[k]) begin
                free_idx = IW'(k);
                free_ok  = 1'b1;
            end
        end
    end

    logic [32:0] key;
    logic [15:0] qeff, delta;
    logic [32:0] end33, dl33;
    logic [15:0] left_new;
    logic        fin_w;
    always_comb begin
        case (r_pol)
            PolRm:   key = {17'd0, r_srd.per};
            PolEdf:  key = {1'b0, r_srd.rel} + {17'd0, r_srd.per};
            default: key = {17'd0, r_srd.left};
        endcase
        qeff = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
        case (r_pol)
            PolFcfs, PolSjf: delta = r_srd.left;
            PolRr:   delta = (qeff > r_srd.left) ? r_srd.left : qeff;
            default: delta = 16'd1;
        endcase
        end33    = {1'b0, r_now} + {17'd0, delta};
        dl33     = {1'b0, r_srd.rel} + {17'd0, r_srd.per};
        left_new = r_srd.left - delta;
        fin_w    = (left_new == 16'd0);
    end

    always_comb begin
        n_state = r_state; n_pcnt = r_pcnt; n_rcnt = r_rcnt; n_i = r_i;
        n_kept = r_kept; n_best = r_best; n_use = r_use; n_now = r_now;
        n_s = r_s; n_bslot = r_bslot; n_bkey = r_bkey; n_pol = r_pol;
        n_ov = r_ov; n_ost = r_ost; n_oid = r_oid; n_ost_t = r_ost_t;
        n_oen = r_oen; n_omiss = r_omiss; n_ofin = r_ofin;
        s_we = 1'b0; s_wa = '0; s_wd = r_srd; s_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
        q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
        in_ch.ready = 1'b0;
        if (out_ch.ready) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                in_ch.ready = !r_ov;
                if (in_ch.valid && !r_ov) begin
                    n_pol = (r_policy > PolEdf) ? PolFcfs : r_policy;
                    n_ost = StRan; n_oid = '0; n_ost_t = '0; n_oen = '0;
                    n_omiss = 1'b0; n_ofin = 1'b0;
                    if (in_ch.cmd == CmdLoad) begin
                        if (!free_ok) begin
                            n_ost = StFull; n_ov = 1'b1;
                        end else begin
                            s_we = 1'b1; s_wa = free_idx;
                            s_wd.id  = in_ch.task_id;
                            s_wd.rel = in_ch.task_release;
                            s_wd.per = in_ch.task_period;
                            s_wd.len = (in_ch.task_length == 16'd0) ? 16'd1
                                                                     : in_ch.task_length;
                            s_wd.left = s_wd.len;
                            n_use[free_idx] = 1'b1;
                            p_we = 1'b1; p_wa = r_pcnt[IW-1:0]; p_wd = free_idx;
                            n_pcnt = r_pcnt + 1'b1;
                            n_ost = StLoad; n_ov = 1'b1;
                        end
                    end else if (r_now >= r_limit) begin
                        n_ost = StLimit; n_ov = 1'b1;
                    end else begin
                        n_i = '0; n_kept = '0;
                        n_state = S_ACT_RD;
                    end
                end
            end
            // activation: read pending entry, then its slot
            S_ACT_RD: begin
                if (r_i == r_pcnt) begin
                    n_pcnt = r_kept;
                    if (r_rcnt == '0) begin
                        n_ost = StIdle; n_ost_t = r_now;
                        n_now = (r_now == '1) ? r_now : r_now + 32'd1;
                        n_oen = n_now; n_ov = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_i = '0; n_best = '0; n_state = S_SEL_RD;
                    end
                end else begin
                    p_ra = r_i[IW-1:0];
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                s_ra = r_prd; n_s = r_prd;
                n_state = S_ACT_CHK;
            end
            S_ACT_CHK: begin
                if (r_srd.rel <= r_now) begin
                    if (r_rcnt < CMAX) begin
                        q_we = 1'b1; q_wa = r_rcnt[IW-1:0]; q_wd = r_s;
                        n_rcnt = r_rcnt + 1'b1;
                    end
                end else begin
                    p_we = 1'b1; p_wa = r_kept[IW-1:0]; p_wd = r_s;
                    n_kept = r_kept + 1'b1;
                end
                n_i = r_i + 1'b1;
                n_state = S_ACT_RD;
            end
            // selection: walk ready list
            S_SEL_RD: begin
                if (r_i == r_rcnt) begin
                    s_ra = r_bslot; n_s = r_bslot;
                    n_state = S_RUN;
                end else begin
                    q_ra = r_i[IW-1:0];
                    n_state = S_RUN_RD;
                end
            end
            S_RUN_RD: begin
                s_ra = r_qrd; n_s = r_qrd;
                n_state = S_SEL_CHK;
            end
            S_SEL_CHK: begin
                if (r_i == '0 || (r_pol >= PolSjf && key < r_bkey)) begin
                    n_best = r_i; n_bkey = key; n_bslot = r_s;
                end
                n_i = r_i + 1'b1;
                n_state = (r_pol < PolSjf) ? S_SEL_RD : S_SEL_RD;
                if (r_pol < PolSjf) n_i = r_rcnt;
            end
            S_RUN: begin
                n_ost = StRan; n_oid = r_srd.id; n_ost_t = r_now;
                n_now = end33[32] ? 32'hFFFF_FFFF : end33[31:0];
                n_oen = n_now;
                n_omiss = (r_pol == PolRm || r_pol == PolEdf) && (end33 > dl33);
                n_ofin = fin_w;
                s_we = 1'b1; s_wa = r_s; s_wd.left = left_new;
                if (fin_w) begin
                    if (r_pol == PolRm || r_pol == PolEdf) begin
                        s_wd.rel = dl33[32] ? 32'hFFFF_FFFF : dl33[31:0];
                        s_wd.left = r_srd.len;
                    end else begin
                        n_use[r_s] = 1'b0;
                    end
                end
                // ready list keeps the entry in place unless it leaves
                if (fin_w || r_pol == PolRr) begin
                    n_i = r_best; n_state = S_SHIFT_RD;
                end else begin
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            S_SHIFT_RD: begin
                if (r_i + 1'b1 >= r_rcnt) begin
                    n_rcnt = r_rcnt - 1'b1;
                    n_state = S_FIN;
                end else begin
                    q_ra = IW'(r_i + 1'b1);
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                q_we = 1'b1; q_wa = r_i[IW-1:0]; q_wd = r_qrd;
                n_i = r_i + 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_FIN: begin
                if ((r_ofin && (r_pol == PolRm || r_pol == PolEdf)) || !r_ofin) begin
                    if (r_pcnt < CMAX) begin
                        p_we = 1'b1; p_wa = r_pcnt[IW-1:0]; p_wd = r_s;
                        n_pcnt = r_pcnt + 1'b1;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ov = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pcnt <= '0; r_rcnt <= '0; r_use <= '0;
            r_now <= '0; r_ov <= 1'b0; r_i <= '0; r_kept <= '0; r_best <= '0;
        end else begin
            r_state <= n_state; r_pcnt <= n_pcnt; r_rcnt <= n_rcnt;
            r_use <= n_use; r_now <= n_now; r_ov <= n_ov; r_i <= n_i;
            r_kept <= n_kept; r_best <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s; r_bslot <= n_bslot; r_bkey <= n_bkey; r_pol <= n_pol;
        r_ost <= n_ost; r_oid <= n_oid; r_ost_t <= n_ost_t; r_oen <= n_oen;
        r_omiss <= n_omiss; r_ofin <= n_ofin;
    end

    assign out_ch.valid           = r_ov;
    assign out_ch.status          = r_ost;
    assign out_ch.run_task_id     = r_oid;
    assign out_ch.start_time      = r_ost_t;
    assign out_ch.end_time        = r_oen;
    assign out_ch.deadline_missed = r_omiss;
    assign out_ch.task_finished   = r_ofin;

`ifndef NO_ASSERTIONS
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= CMAX && r_rcnt <= CMAX) else $error("list count overflow");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |-> (r_state == S_IDLE && !r_ov))
        else $error("item accepted while busy");
    a_now_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_now >= $past(r_now)) else $error("time went back");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> (r_ov && $stable(r_ost)))
        else $error("result lost under stall");
`endif
endmodule
`default_nettype wire
